@@ hdl/kaq_pkg.sv @@
// Shared types, constants and register codes for the key auto-repeat qualifier.
package kaq_pkg;

    // Field widths of the configuration registers.
    localparam int REPEAT_W  = 11;
    localparam int CONFIRM_W = 12;
    localparam int STEP_W    = 11;
    localparam int DELAY_W   = 12;
    localparam int EVENT_W   = 3;

    // Reset values of the configuration registers and of the hold counters.
    localparam int RST_REPEAT_DELAY  = 150;
    localparam int RST_CONFIRM_DELAY = 1200;
    localparam int RST_ACCEL_STEP    = 65;
    localparam int RESET_COUNT       = 150;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_ACCEL_LEVEL = 2;
    localparam int DEF_COUNTER_BITS    = 12;

    // Key slots, in the order the counters are kept.
    localparam int NUM_KEYS    = 6;
    localparam int KEY_CONFIRM = 0;
    localparam int KEY_DOWN    = 1;
    localparam int KEY_UP      = 2;
    localparam int KEY_CHANGE  = 3;
    localparam int KEY_LEFT    = 4;
    localparam int KEY_RIGHT   = 5;

    // Configuration bus geometry: three 32-bit registers at 0, 4 and 8.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_REPEAT_DELAY  = 2'd0,
        REG_CONFIRM_DELAY = 2'd1,
        REG_ACCEL_STEP    = 2'd2
    } t_reg_idx;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_DOWN    = 3'd1,
        EV_UP      = 3'd2,
        EV_CHANGE  = 3'd3,
        EV_LEFT    = 3'd4,
        EV_RIGHT   = 3'd5,
        EV_CONFIRM = 3'd6
    } t_key_event;

endpackage

@@ hdl/kaq_key_cell.sv @@
// Hold counter of one key: release preset, count while held, fire and reload.
module kaq_key_cell
    import kaq_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_pressed,
    input  logic [DELAY_W-1:0]      i_delay,
    input  logic [COUNTER_BITS-1:0] i_reload,
    output logic                    o_fire
);

    localparam int WW      = (COUNTER_BITS > DELAY_W) ? COUNTER_BITS : DELAY_W;
    localparam int CNT_MAX = (1 << COUNTER_BITS) - 1;
    localparam logic [COUNTER_BITS-1:0] CNT_RST =
        (RESET_COUNT > CNT_MAX) ? COUNTER_BITS'(CNT_MAX) : COUNTER_BITS'(RESET_COUNT);

    logic [COUNTER_BITS-1:0] r_cnt;
    logic [COUNTER_BITS-1:0] n_cnt;
    logic [WW-1:0]           w_delay_ext;
    logic [COUNTER_BITS-1:0] w_delay;
    logic                    w_below;

    // A delay beyond the counter range acts as the counter maximum.
    assign w_delay_ext = WW'(i_delay);
    assign w_delay = (w_delay_ext > WW'(CNT_MAX)) ? COUNTER_BITS'(CNT_MAX)
                                                  : w_delay_ext[COUNTER_BITS-1:0];
    assign w_below = (r_cnt < w_delay);
    assign o_fire  = i_pressed && !w_below;

    // Next counter value for the current tick.
    always_comb begin
        if (!i_pressed) begin
            n_cnt = w_delay;
        end else if (w_below) begin
            n_cnt = COUNTER_BITS'(r_cnt + 1'b1);
        end else begin
            n_cnt = i_reload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_RST;
        end else if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hdl/kaq_accel.sv @@
// Acceleration level of one direction key and its saturated counter preload.
module kaq_accel
    import kaq_pkg::*;
#(
    parameter int MAX_ACCEL_LEVEL = DEF_MAX_ACCEL_LEVEL,
    parameter int COUNTER_BITS    = DEF_COUNTER_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_pressed,
    input  logic                    i_fire,
    input  logic [STEP_W-1:0]       i_step,
    output logic [COUNTER_BITS-1:0] o_preload
);

    localparam int LVL_W   = $clog2(MAX_ACCEL_LEVEL + 1);
    localparam int PW      = LVL_W + STEP_W;
    localparam int WW      = (PW > COUNTER_BITS) ? PW : COUNTER_BITS;
    localparam int CNT_MAX = (1 << COUNTER_BITS) - 1;

    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic [PW-1:0]    w_prod;
    logic [WW-1:0]    w_prod_ext;

    // Preload is level times step, saturated at the counter maximum.
    assign w_prod     = PW'(r_level) * PW'(i_step);
    assign w_prod_ext = WW'(w_prod);
    assign o_preload  = (w_prod_ext > WW'(CNT_MAX)) ? COUNTER_BITS'(CNT_MAX)
                                                   : w_prod_ext[COUNTER_BITS-1:0];

    // Release clears the level; each firing raises it up to the maximum.
    always_comb begin
        n_level = r_level;
        if (!i_pressed) begin
            n_level = '0;
        end else if (i_fire && (r_level < LVL_W'(MAX_ACCEL_LEVEL))) begin
            n_level = LVL_W'(r_level + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_en) begin
            r_level <= n_level;
        end
    end

endmodule

@@ hdl/kaq_out_skid.sv @@
// Result register with a skid stage so the input side keeps moving under a stall.
module kaq_out_skid
    import kaq_pkg::*;
#(
    parameter int WIDTH = EVENT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_in_fire;
    logic             w_out_fire;

    assign o_stall    = r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_stall;

    // Control: the skid only fills when the result register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves with the control above.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_in_fire) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

endmodule

@@ hdl/key_autorepeat_qualifier.sv @@
// Top level of the key auto-repeat qualifier with direction-key acceleration.
// An accepted tick's key event is registered in the result register, or in the
// skid stage while an earlier event is still held by a stall downstream.
// One tick per cycle unless the input stalls; the counters step on accepted ticks.
// A two-deep result buffer keeps ticks flowing while one result waits downstream.
// Reset is synchronous and active low: counters preset to 150, levels to zero,
// registers to 150, 1200 and 65, and the result buffer empties.
module key_autorepeat_qualifier
    import kaq_pkg::*;
#(
    parameter int MAX_ACCEL_LEVEL = DEF_MAX_ACCEL_LEVEL,
    parameter int COUNTER_BITS    = DEF_COUNTER_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Tick channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_confirm_pressed,
    input  logic                  i_down_pressed,
    input  logic                  i_up_pressed,
    input  logic                  i_change_pressed,
    input  logic                  i_left_pressed,
    input  logic                  i_right_pressed,
    // Event channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [EVENT_W-1:0]    o_key_event
);

    logic [REPEAT_W-1:0]  r_repeat_delay;
    logic [CONFIRM_W-1:0] r_confirm_delay;
    logic [STEP_W-1:0]    r_accel_step;
    logic                 w_cfg_wr;
    t_reg_idx             w_reg_idx;
    logic                 w_accept;
    logic [NUM_KEYS-1:0]  w_pressed;
    logic [NUM_KEYS-1:0]  w_fire;
    logic [DELAY_W-1:0]   w_delay [NUM_KEYS];
    logic [COUNTER_BITS-1:0] w_reload [NUM_KEYS];
    t_key_event           w_event;

    // Configuration registers.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= REPEAT_W'(RST_REPEAT_DELAY);
            r_confirm_delay <= CONFIRM_W'(RST_CONFIRM_DELAY);
            r_accel_step    <= STEP_W'(RST_ACCEL_STEP);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_REPEAT_DELAY:  r_repeat_delay  <= pwdata[REPEAT_W-1:0];
                REG_CONFIRM_DELAY: r_confirm_delay <= pwdata[CONFIRM_W-1:0];
                REG_ACCEL_STEP:    r_accel_step    <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            REG_REPEAT_DELAY:  prdata = APB_DATA_W'(r_repeat_delay);
            REG_CONFIRM_DELAY: prdata = APB_DATA_W'(r_confirm_delay);
            REG_ACCEL_STEP:    prdata = APB_DATA_W'(r_accel_step);
            default:           prdata = '0;
        endcase
    end

    // A tick is taken whenever the result buffer has room.
    assign w_accept = i_in_valid && !o_in_stall;

    assign w_pressed[KEY_CONFIRM] = i_confirm_pressed;
    assign w_pressed[KEY_DOWN]    = i_down_pressed;
    assign w_pressed[KEY_UP]      = i_up_pressed;
    assign w_pressed[KEY_CHANGE]  = i_change_pressed;
    assign w_pressed[KEY_LEFT]    = i_left_pressed;
    assign w_pressed[KEY_RIGHT]   = i_right_pressed;

    // Delays and reload values per key.
    assign w_delay[KEY_CONFIRM]  = r_confirm_delay;
    assign w_delay[KEY_DOWN]     = DELAY_W'(r_repeat_delay);
    assign w_delay[KEY_UP]       = DELAY_W'(r_repeat_delay);
    assign w_delay[KEY_CHANGE]   = DELAY_W'(r_repeat_delay);
    assign w_delay[KEY_LEFT]     = DELAY_W'(r_repeat_delay);
    assign w_delay[KEY_RIGHT]    = DELAY_W'(r_repeat_delay);
    assign w_reload[KEY_CONFIRM] = '0;
    assign w_reload[KEY_DOWN]    = '0;
    assign w_reload[KEY_UP]      = '0;
    assign w_reload[KEY_CHANGE]  = '0;

    // One hold counter per key.
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
        kaq_key_cell #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_accept),
            .i_pressed (w_pressed[g]),
            .i_delay   (w_delay[g]),
            .i_reload  (w_reload[g]),
            .o_fire    (w_fire[g])
        );
    end

    // Acceleration for the left and right keys.
    kaq_accel #(
        .MAX_ACCEL_LEVEL (MAX_ACCEL_LEVEL),
        .COUNTER_BITS    (COUNTER_BITS)
    ) u_accel_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_accept),
        .i_pressed (w_pressed[KEY_LEFT]),
        .i_fire    (w_fire[KEY_LEFT]),
        .i_step    (r_accel_step),
        .o_preload (w_reload[KEY_LEFT])
    );

    kaq_accel #(
        .MAX_ACCEL_LEVEL (MAX_ACCEL_LEVEL),
        .COUNTER_BITS    (COUNTER_BITS)
    ) u_accel_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_accept),
        .i_pressed (w_pressed[KEY_RIGHT]),
        .i_fire    (w_fire[KEY_RIGHT]),
        .i_step    (r_accel_step),
        .o_preload (w_reload[KEY_RIGHT])
    );

    // Fixed priority: right, left, change, up, down, confirm.
    always_comb begin
        if (w_fire[KEY_RIGHT]) begin
            w_event = EV_RIGHT;
        end else if (w_fire[KEY_LEFT]) begin
            w_event = EV_LEFT;
        end else if (w_fire[KEY_CHANGE]) begin
            w_event = EV_CHANGE;
        end else if (w_fire[KEY_UP]) begin
            w_event = EV_UP;
        end else if (w_fire[KEY_DOWN]) begin
            w_event = EV_DOWN;
        end else if (w_fire[KEY_CONFIRM]) begin
            w_event = EV_CONFIRM;
        end else begin
            w_event = EV_NONE;
        end
    end

    // Result register and skid stage.
    kaq_out_skid #(
        .WIDTH (EVENT_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (w_event),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_key_event)
    );

endmodule

@@ hdl/kaq_checker.sv @@
// Port-level checks for the key auto-repeat qualifier, bound to the top level.
module kaq_checker
    import kaq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [EVENT_W-1:0] o_key_event
);

    // A shown event is always one of the defined codes.
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_event <= EV_CONFIRM))
        else $error("key event code out of range");

    // A held result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_key_event)))
        else $error("stalled key event changed");

    // Every accepted tick leaves a result on the output next cycle.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted tick produced no result");

    // The input side only stalls after the output side has held a result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

bind key_autorepeat_qualifier kaq_checker u_kaq_checker (.*);
